@@ hdl/swml_pkg.sv @@
// Package for the sliding-window majority label smoother.
// Holds sizes, register indexes, the controller state type and the voter control struct.
// No dependencies.
package swml_pkg;

	localparam int WINDOW_MAX = 32;
	localparam int LABEL_BITS = 8;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int WLEN_W     = 6;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NO_GESTURE_CODE = 1'd1;

	localparam logic [WLEN_W-1:0]     WLEN_RESET = 6'd8;
	localparam logic [LABEL_BITS-1:0] NG_RESET   = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} swml_state_t;

	// Control for the voting unit for one scan beat.
	typedef struct packed {
		logic active;
		logic first;
	} swml_vote_ctl_t;

endpackage

@@ hdl/swml_cell.sv @@
// One history cell: a single label register in the chain.
// Loads from its neighbour whenever the chain moves. Uses swml_pkg.
module swml_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          move,
	input  logic [swml_pkg::LABEL_BITS-1:0] d,
	output logic [swml_pkg::LABEL_BITS-1:0] q
);
	import swml_pkg::*;

	logic [LABEL_BITS-1:0] entry_q;

	// History refills with the reset no-gesture code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= NG_RESET;
		end else if (move) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

@@ hdl/swml_voter.sv @@
// Majority voting unit: takes one history entry per beat, oldest first.
// Keeps the candidate and its count. Uses swml_pkg.
module swml_voter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swml_pkg::swml_vote_ctl_t        ctl,
	input  logic [swml_pkg::LABEL_BITS-1:0] entry,
	output logic [swml_pkg::LABEL_BITS-1:0] cand
);
	import swml_pkg::*;

	logic [LABEL_BITS-1:0] cand_q;
	logic [CNT_W-1:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.active) begin
			if (ctl.first || (entry != cand_q && count_q == CNT_W'(1))) begin
				count_q <= CNT_W'(1);
			end else if (entry == cand_q) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// A mismatch while the count is one hands over the candidacy, as does the first beat.
	always_ff @(posedge clk) begin
		if (ctl.active && (ctl.first || (entry != cand_q && count_q == CNT_W'(1)))) begin
			cand_q <= entry;
		end
	end

	assign cand = cand_q;

endmodule

@@ hdl/sliding_window_majority_label_top.sv @@
// Top level of the sliding-window majority label smoother.
// Chain of swml_cell history cells, one swml_voter and the controller. Uses swml_pkg.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_tvalid/s_tready | tdata: label, tuser: present
//   m_      | out       | m_tvalid/m_tready | tdata: out_label, tuser: out_valid
//   cfg_    | in        | cfg_we            | cfg_index, cfg_data
//
// A label beat shifts into the chain in the cycle it is accepted. The controller then
// scans, with the chain rotating once past the voter, one entry a cycle, and then loads
// the output register before it takes the next beat. An absent or no-gesture beat is
// not shifted in and skips the scan. Reset refills the history with the reset no-gesture code at once.
// A result waiting on m_tready holds the controller in its emit state.
module sliding_window_majority_label_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [swml_pkg::LABEL_BITS-1:0]      s_tdata,  // [7:0] label
	input  logic                                 s_tuser,  // [0] present
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [swml_pkg::LABEL_BITS-1:0]      m_tdata,  // [7:0] out_label
	output logic                                 m_tuser,  // [0] out_valid
	input  logic                                 cfg_we,
	input  logic [swml_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swml_pkg::CFG_W-1:0]           cfg_data
);
	import swml_pkg::*;

	logic [WLEN_W-1:0]     wlen_q;
	logic [LABEL_BITS-1:0] ng_code_q;
	swml_state_t           state_q, state_d;
	logic [IDX_W-1:0]      step_q;
	logic                  res_valid_q;
	logic                  m_tvalid_q;
	logic [LABEL_BITS-1:0] m_tdata_q;
	logic                  m_tuser_q;

	logic [LABEL_BITS-1:0] hist [WINDOW_MAX];
	logic [LABEL_BITS-1:0] tail;
	logic                  move;
	logic                  accept;
	logic                  is_label;
	logic                  out_free;
	logic                  load_out;
	logic                  step_last;
	logic [CNT_W-1:0]      eff_len;
	logic [CNT_W:0]        reach;
	swml_vote_ctl_t        vote_ctl;
	logic [LABEL_BITS-1:0] cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= WLEN_RESET;
			ng_code_q <= NG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:   wlen_q    <= cfg_data[WLEN_W-1:0];
				REG_NO_GESTURE_CODE: ng_code_q <= cfg_data[LABEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Zero scans one entry; anything above the depth scans all of it.
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = CNT_W'(1);
		end else if ({1'b0, wlen_q} > (WLEN_W+1)'(WINDOW_MAX)) begin
			eff_len = CNT_W'(WINDOW_MAX);
		end else begin
			eff_len = CNT_W'(wlen_q);
		end
	end

	// Position step holds entry index step in cell 0; it is in the window when
	// step + length reaches the depth.
	assign reach     = (CNT_W+1)'(step_q) + (CNT_W+1)'(eff_len);
	assign step_last = (step_q == IDX_W'(WINDOW_MAX - 1));
	assign accept    = s_tvalid && s_tready;
	assign is_label  = s_tuser && (s_tdata != ng_code_q);
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = is_label ? ST_SCAN : ST_EMIT;
			ST_SCAN: if (step_last) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		move            = 1'b0;
		load_out        = 1'b0;
		vote_ctl.active = 1'b0;
		vote_ctl.first  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				move     = accept && is_label;
			end
			ST_SCAN: begin
				move            = 1'b1;
				vote_ctl.active = (reach >= (CNT_W+1)'(WINDOW_MAX));
				vote_ctl.first  = (reach == (CNT_W+1)'(WINDOW_MAX));
			end
			ST_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				step_q <= '0;
			end else if (state_q == ST_SCAN) begin
				step_q <= step_q + IDX_W'(1);
			end
			if (accept) begin
				res_valid_q <= is_label;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser_q <= res_valid_q;
			m_tdata_q <= res_valid_q ? cand : '0;
		end
	end

	// New labels enter at the newest end; during a scan the oldest wraps round.
	assign tail = (state_q == ST_IDLE) ? s_tdata : hist[0];

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [LABEL_BITS-1:0] nbr;
		if (i == WINDOW_MAX - 1) begin : g_tail
			assign nbr = tail;
		end else begin : g_body
			assign nbr = hist[i+1];
		end
		swml_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.move   (move),
			.d      (nbr),
			.q      (hist[i])
		);
	end

	swml_voter u_voter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (vote_ctl),
		.entry  (hist[0]),
		.cand   (cand)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
